// File: rtl/lbf_pkg.sv
package lbf_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned OFF_W       = 17;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned NUM_SLOTS   = 3;
  localparam int unsigned OUT_DATA_W  = 96;

  localparam logic [OFF_W-1:0] HDR_BYTES  = 17'd7;
  localparam logic [OFF_W-1:0] BLOCK_MIN  = 17'd8;
  localparam logic [OFF_W-1:0] BLOCK_MAX  = 17'd65542;
  localparam logic [OFF_W-1:0] BLOCK_RST  = 17'd32768;
  localparam logic [LEN_W-1:0] MAX_FRAG   = 16'hFFFF;
  localparam logic [31:0]      CRC_POLY   = 32'hEDB88320;

  // Slot order inside one result bank.
  localparam int unsigned SLOT_PRE   = 0;
  localparam int unsigned SLOT_BYTE  = 1;
  localparam int unsigned SLOT_CLOSE = 2;

  typedef enum logic [1:0] {
    KIND_PAD  = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_HDR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    FT_NONE   = 3'd0,
    FT_FULL   = 3'd1,
    FT_FIRST  = 3'd2,
    FT_MIDDLE = 3'd3,
    FT_LAST   = 3'd4
  } ftype_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        byte_value;
    logic [2:0]        pad_length;
    logic [31:0]       checksum;
    logic [LEN_W-1:0]  frag_len;
    ftype_t            frag_type;
  } res_t;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [ADDR_W-1:0] wp;
    logic              open;
    logic [ADDR_W-1:0] hdr_addr;
    logic [LEN_W-1:0]  pcount;
    logic              at_start;
    logic [31:0]       crc_end;
    logic [31:0]       crc_cont;
  } state_t;

  // Byte-wide update of the reflected CRC32 (zlib form, pre/post inverted).
  function automatic logic [31:0] crc_add(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  function automatic logic [7:0] type_byte(input ftype_t t);
    return {5'd0, t};
  endfunction

endpackage

// File: rtl/lbf_step.sv
module lbf_step (
  input  lbf_pkg::state_t           st_i,
  input  logic [lbf_pkg::OFF_W-1:0] blk_bytes_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      record_last_i,
  input  logic                      record_empty_i,
  output lbf_pkg::state_t           st_o,
  output lbf_pkg::res_t             res_pre_o,
  output lbf_pkg::res_t             res_byte_o,
  output lbf_pkg::res_t             res_close_o,
  output logic [lbf_pkg::NUM_SLOTS-1:0] res_v_o
);

  logic [lbf_pkg::OFF_W-1:0]  bs;
  logic [lbf_pkg::OFF_W-1:0]  left0;
  logic [lbf_pkg::OFF_W-1:0]  left1;
  logic                       pad;
  logic                       zhdr;
  logic [lbf_pkg::ADDR_W-1:0] wp1;
  logic [lbf_pkg::ADDR_W-1:0] wp2;
  logic [lbf_pkg::OFF_W-1:0]  off1;
  logic [lbf_pkg::OFF_W-1:0]  off2;
  logic                       start2;
  lbf_pkg::state_t            op;
  lbf_pkg::ftype_t            zh_type;
  logic [lbf_pkg::OFF_W-1:0]  off4;

  always_comb begin
    if (blk_bytes_i < lbf_pkg::BLOCK_MIN) begin
      bs = lbf_pkg::BLOCK_MIN;
    end else if (blk_bytes_i > lbf_pkg::BLOCK_MAX) begin
      bs = lbf_pkg::BLOCK_MAX;
    end else begin
      bs = blk_bytes_i;
    end
  end

  // Opening a fragment: optional padding or a zero-length filler header,
  // then the header space is reserved.
  always_comb begin
    left0   = (st_i.off >= bs) ? '0 : bs - st_i.off;
    pad     = left0 < lbf_pkg::HDR_BYTES;
    wp1     = st_i.wp + (pad ? lbf_pkg::ADDR_W'(left0) : '0);
    off1    = pad ? '0 : st_i.off;
    left1   = pad ? bs : left0;
    zhdr    = !record_empty_i && (left1 == lbf_pkg::HDR_BYTES);
    zh_type = st_i.at_start ? lbf_pkg::FT_FIRST : lbf_pkg::FT_MIDDLE;
    wp2     = wp1 + (zhdr ? lbf_pkg::ADDR_W'(lbf_pkg::HDR_BYTES) : '0);
    off2    = zhdr ? '0 : off1;
    start2  = zhdr ? 1'b0 : st_i.at_start;

    if (st_i.open) begin
      op = st_i;
    end else begin
      op.hdr_addr = wp2;
      op.wp       = wp2 + lbf_pkg::ADDR_W'(lbf_pkg::HDR_BYTES);
      op.off      = off2 + lbf_pkg::HDR_BYTES;
      op.pcount   = '0;
      op.open     = 1'b1;
      op.at_start = start2;
      op.crc_end  = lbf_pkg::crc_add(32'd0, lbf_pkg::type_byte(
                      start2 ? lbf_pkg::FT_FULL : lbf_pkg::FT_LAST));
      op.crc_cont = lbf_pkg::crc_add(32'd0, lbf_pkg::type_byte(
                      start2 ? lbf_pkg::FT_FIRST : lbf_pkg::FT_MIDDLE));
    end
  end

  always_comb begin
    res_pre_o            = '0;
    res_pre_o.kind       = zhdr ? lbf_pkg::KIND_HDR : lbf_pkg::KIND_PAD;
    res_pre_o.addr       = zhdr ? wp1 : st_i.wp;
    res_pre_o.pad_length = zhdr ? 3'd0 : left0[2:0];
    res_pre_o.checksum   = zhdr ? lbf_pkg::crc_add(32'd0, lbf_pkg::type_byte(zh_type)) : '0;
    res_pre_o.frag_type  = zhdr ? zh_type : lbf_pkg::FT_NONE;

    res_byte_o            = '0;
    res_byte_o.kind       = lbf_pkg::KIND_BYTE;
    res_byte_o.addr       = op.wp;
    res_byte_o.byte_value = data_byte_i;

    st_o = op;
    off4 = op.off;
    if (!record_empty_i) begin
      st_o.crc_end  = lbf_pkg::crc_add(op.crc_end, data_byte_i);
      st_o.crc_cont = lbf_pkg::crc_add(op.crc_cont, data_byte_i);
      if (op.pcount != lbf_pkg::MAX_FRAG) begin
        st_o.pcount = op.pcount + 16'd1;
      end
      st_o.wp = op.wp + 32'd1;
      off4    = op.off + 17'd1;
      st_o.off = off4;
    end

    res_close_o          = '0;
    res_close_o.kind     = lbf_pkg::KIND_HDR;
    res_close_o.addr     = op.hdr_addr;
    res_close_o.frag_len = st_o.pcount;
    res_v_o              = '0;
    res_v_o[lbf_pkg::SLOT_PRE]  = !st_i.open && ((pad && left0 != '0) || zhdr);
    res_v_o[lbf_pkg::SLOT_BYTE] = !record_empty_i;

    priority if (record_empty_i || record_last_i) begin
      res_close_o.checksum  = st_o.crc_end;
      res_close_o.frag_type = op.at_start ? lbf_pkg::FT_FULL : lbf_pkg::FT_LAST;
      res_v_o[lbf_pkg::SLOT_CLOSE] = 1'b1;
      st_o.open     = 1'b0;
      st_o.at_start = 1'b1;
    end else if (off4 >= bs || st_o.pcount == lbf_pkg::MAX_FRAG) begin
      res_close_o.checksum  = st_o.crc_cont;
      res_close_o.frag_type = op.at_start ? lbf_pkg::FT_FIRST : lbf_pkg::FT_MIDDLE;
      res_v_o[lbf_pkg::SLOT_CLOSE] = 1'b1;
      st_o.open     = 1'b0;
      st_o.at_start = 1'b0;
    end else begin
      res_close_o.checksum  = '0;
      res_close_o.frag_type = lbf_pkg::FT_NONE;
    end
  end

endmodule

// File: rtl/log_record_block_framer.sv
// Channel   Dir  Handshake           Payload
// in_       in   in_tvalid/tready    tdata: data_byte; tlast: record_last;
//                                     tuser: record_empty
// out_      out  out_tvalid/tready   tdata: address..type; tuser: kind;
//                                     tlast: last result of an input
// cfg_      in   cfg_we              cfg_wdata: bytes per block
//
// An input transfer lands in the input register; once the result bank is free, the framing step
// works it out in one pass and loads one to three results into the result bank.
// Results leave one per cycle while out_tready is high, so an input holds the bank until all
// of its results have left; an input passes the input register, then the result bank.
// The result bank is the only throughput limit: a new input is taken while results wait.
// Reset (synchronous, rst_n low) empties both registers, restores the framing state and block size.
module log_record_block_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // record_last
  input  logic        in_tuser,   // record_empty
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] log_address, [39:32] byte_value, [42:40] pad_length, [74:43] checksum,
  // [90:75] fragment payload length, [93:91] fragment_type, [95:94] zero
  output logic [95:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last_result
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata   // bytes per block
);

  logic [lbf_pkg::OFF_W-1:0] blk_bytes_r;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       in_empty_r;

  lbf_pkg::state_t st_r;
  lbf_pkg::state_t st_nxt;

  lbf_pkg::res_t  res_r [lbf_pkg::NUM_SLOTS];
  logic [lbf_pkg::NUM_SLOTS-1:0] res_v_r;
  logic [lbf_pkg::NUM_SLOTS-1:0] res_v_nxt;

  lbf_pkg::res_t  step_pre;
  lbf_pkg::res_t  step_byte;
  lbf_pkg::res_t  step_close;
  logic [lbf_pkg::NUM_SLOTS-1:0] step_v;

  logic [lbf_pkg::NUM_SLOTS-1:0] sel_oh;
  logic [lbf_pkg::NUM_SLOTS-1:0] rest_v;
  lbf_pkg::res_t  sel_res;
  logic           take;
  logic           bank_free;
  logic           load;
  logic           in_accept;

  lbf_step u_step (
    .st_i           (st_r),
    .blk_bytes_i    (blk_bytes_r),
    .data_byte_i    (in_byte_r),
    .record_last_i  (in_last_r),
    .record_empty_i (in_empty_r),
    .st_o           (st_nxt),
    .res_pre_o      (step_pre),
    .res_byte_o     (step_byte),
    .res_close_o    (step_close),
    .res_v_o        (step_v)
  );

  // Results leave in slot order; the lowest valid slot is shown.
  always_comb begin
    priority if (res_v_r[lbf_pkg::SLOT_PRE]) begin
      sel_oh  = 3'b001;
      sel_res = res_r[lbf_pkg::SLOT_PRE];
    end else if (res_v_r[lbf_pkg::SLOT_BYTE]) begin
      sel_oh  = 3'b010;
      sel_res = res_r[lbf_pkg::SLOT_BYTE];
    end else begin
      sel_oh  = {res_v_r[lbf_pkg::SLOT_CLOSE], 2'b00};
      sel_res = res_r[lbf_pkg::SLOT_CLOSE];
    end
  end

  assign rest_v     = res_v_r & ~sel_oh;
  assign out_tvalid = |res_v_r;
  assign take       = out_tvalid && out_tready;
  assign bank_free  = !out_tvalid || (take && rest_v == '0);
  assign load       = in_v_r && bank_free;
  assign in_tready  = !in_v_r || load;
  assign in_accept  = in_tvalid && in_tready;

  assign out_tuser = sel_res.kind;
  assign out_tlast = out_tvalid && rest_v == '0;
  assign out_tdata = {2'b00, sel_res.frag_type, sel_res.frag_len, sel_res.checksum,
                      sel_res.pad_length, sel_res.byte_value, sel_res.addr};

  always_comb begin
    if (load) begin
      res_v_nxt = step_v;
    end else if (take) begin
      res_v_nxt = rest_v;
    end else begin
      res_v_nxt = res_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_bytes_r <= lbf_pkg::BLOCK_RST;
      in_v_r      <= 1'b0;
      res_v_r     <= '0;
      st_r        <= '{off: '0, wp: '0, open: 1'b0, hdr_addr: '0, pcount: '0,
                       at_start: 1'b1, crc_end: '0, crc_cont: '0};
    end else begin
      if (cfg_we) begin
        blk_bytes_r <= cfg_wdata;
      end
      if (in_accept) begin
        in_v_r <= 1'b1;
      end else if (load) begin
        in_v_r <= 1'b0;
      end
      res_v_r <= res_v_nxt;
      if (load) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r  <= in_tdata;
      in_last_r  <= in_tlast;
      in_empty_r <= in_tuser;
    end
    if (load) begin
      res_r[lbf_pkg::SLOT_PRE]   <= step_pre;
      res_r[lbf_pkg::SLOT_BYTE]  <= step_byte;
      res_r[lbf_pkg::SLOT_CLOSE] <= step_close;
    end
  end

`ifndef SYNTH
  // Every input produces at least one result.
  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> res_v_r != '0)
    else $error("input produced no result");

  // While a fragment is open, the pointer sits past its header and payload.
  a_open_span: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.open |-> (st_r.wp - st_r.hdr_addr) == (32'(st_r.pcount) + 32'd7))
    else $error("open fragment span does not match its payload count");

  // An open fragment never holds a full-length payload.
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.open |-> st_r.pcount != lbf_pkg::MAX_FRAG)
    else $error("fragment left open at maximum length");

  // A buffered input is not dropped while the result bank is busy.
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !load) |=> in_v_r)
    else $error("buffered input lost");

  // The final result of an input is the last one in the bank.
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> $countones(res_v_r) == 1)
    else $error("last marker with results still pending");
`endif

endmodule

// File: verif/log_record_block_framer_tb.sv
module log_record_block_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    kind_t       kind;
    logic [31:0] addr;
    logic [7:0]  value;
    logic [2:0]  pad;
    logic [31:0] crc;
    logic [15:0] len;
    ftype_t      ftype;
    logic        ends_input;
  } log_write_t;

  // Tracks the framing state and the log writes that accepted input transfers still owe.
  class framer_scoreboard;
    logic [16:0] blk_bytes;
    logic [16:0] offset;
    logic [31:0] wr_ptr;
    logic [31:0] hdr_addr;
    logic [31:0] crc_end;
    logic [31:0] crc_cont;
    logic        frag_open;
    logic        rec_start;
    logic [15:0] frag_bytes;
    log_write_t  writes_due[$];
    int unsigned errors;

    function new();
      blk_bytes  = BLOCK_RST;
      offset     = '0;
      wr_ptr     = '0;
      hdr_addr   = '0;
      crc_end    = '0;
      crc_cont   = '0;
      frag_open  = 1'b0;
      rec_start  = 1'b1;
      frag_bytes = '0;
      errors     = 0;
    endfunction

    // Reflected CRC32, feeding one message bit per step.
    function logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      logic        fb;
      c = ~crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return ~c;
    endfunction

    function void emit(kind_t k, logic [31:0] a, logic [7:0] v, logic [2:0] p,
                       logic [31:0] c, logic [15:0] l, ftype_t t);
      log_write_t w;
      w.kind       = k;
      w.addr       = a;
      w.value      = v;
      w.pad        = p;
      w.crc        = c;
      w.len        = l;
      w.ftype      = t;
      w.ends_input = 1'b0;
      writes_due.push_back(w);
    endfunction

    function void note_input(logic [7:0] b, logic rec_last, logic rec_empty);
      logic [16:0] bs;
      logic [16:0] room;
      ftype_t      t;
      if (blk_bytes < BLOCK_MIN) bs = BLOCK_MIN;
      else if (blk_bytes > BLOCK_MAX) bs = BLOCK_MAX;
      else bs = blk_bytes;

      if (!frag_open) begin
        room = (offset >= bs) ? '0 : bs - offset;
        if (room < HDR_BYTES) begin
          if (room != 0) begin
            emit(KIND_PAD, wr_ptr, 8'd0, room[2:0], 32'd0, 16'd0, FT_NONE);
            wr_ptr += 32'(room);
          end
          offset = '0;
          room   = bs;
        end
        // A header with no payload fills the block when a byte finds exactly seven left.
        if (!rec_empty && room == HDR_BYTES) begin
          t = rec_start ? FT_FIRST : FT_MIDDLE;
          emit(KIND_HDR, wr_ptr, 8'd0, 3'd0, crc_fold(32'd0, 8'(t)), 16'd0, t);
          wr_ptr   += 32'(HDR_BYTES);
          offset    = '0;
          rec_start = 1'b0;
        end
        hdr_addr   = wr_ptr;
        wr_ptr    += 32'(HDR_BYTES);
        offset    += HDR_BYTES;
        frag_bytes = '0;
        frag_open  = 1'b1;
        crc_end    = crc_fold(32'd0, rec_start ? 8'(FT_FULL) : 8'(FT_LAST));
        crc_cont   = crc_fold(32'd0, rec_start ? 8'(FT_FIRST) : 8'(FT_MIDDLE));
      end

      if (!rec_empty) begin
        emit(KIND_BYTE, wr_ptr, b, 3'd0, 32'd0, 16'd0, FT_NONE);
        crc_end  = crc_fold(crc_end, b);
        crc_cont = crc_fold(crc_cont, b);
        if (frag_bytes != MAX_FRAG) frag_bytes++;
        wr_ptr++;
        offset++;
      end

      if (rec_empty || rec_last) begin
        emit(KIND_HDR, hdr_addr, 8'd0, 3'd0, crc_end, frag_bytes,
             rec_start ? FT_FULL : FT_LAST);
        frag_open = 1'b0;
        rec_start = 1'b1;
      end else if (offset >= bs || frag_bytes == MAX_FRAG) begin
        emit(KIND_HDR, hdr_addr, 8'd0, 3'd0, crc_cont, frag_bytes,
             rec_start ? FT_FIRST : FT_MIDDLE);
        frag_open = 1'b0;
        rec_start = 1'b0;
      end

      writes_due[writes_due.size() - 1].ends_input = 1'b1;
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        if (errors <= 100)
          $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [95:0] d, logic [1:0] u, logic l);
      log_write_t w;
      if (writes_due.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected result: expected none, actual tdata %h tuser %0d",
                   $time, d, u);
        return;
      end
      w = writes_due.pop_front();
      compare("kind", 32'(w.kind), 32'(u));
      compare("log_address", w.addr, d[31:0]);
      compare("byte_value", 32'(w.value), 32'(d[39:32]));
      compare("pad_length", 32'(w.pad), 32'(d[42:40]));
      compare("checksum", w.crc, d[74:43]);
      compare("frag_len", 32'(w.len), 32'(d[90:75]));
      compare("fragment_type", 32'(w.ftype), 32'(d[93:91]));
      compare("last_result", 32'(w.ends_input), 32'(l));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [16:0] cfg_wdata  = '0;

  framer_scoreboard sb = new();
  bit               steady   = 1'b0;
  int unsigned      rec_left = 0;
  int unsigned      cycles   = 0;

  log_record_block_framer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 8);
  end

  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic rec_last, input logic rec_empty);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= rec_last;
    in_tuser  <= rec_empty;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_tvalid <= 1'b0;
    while (sb.writes_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_blk_bytes(input logic [16:0] size);
    wait_drained(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    sb.blk_bytes = size;
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed records of random length; now and then an empty marker cuts one short.
  task automatic random_items(input int n, input int unsigned max_len);
    int unsigned roll;
    for (int k = 0; k < n; k++) begin
      if (rec_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
          continue;
        end
        rec_left = (roll < 80) ? $urandom_range(1, max_len) : $urandom_range(1, 3 * max_len);
      end
      if ($urandom_range(0, 99) < 3) begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        rec_left = 0;
      end else begin
        send_item(8'($urandom_range(0, 255)), rec_left == 1, 1'b0);
        rec_left--;
      end
    end
  endtask

  task automatic run_phase(input logic [16:0] size, input int n, input int unsigned max_len);
    write_blk_bytes(size);
    random_items(n, max_len);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset block size: an empty record, then a two-byte record.
    send_item(8'h3C, 1'b0, 1'b1);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);

    // Sixteen-byte blocks: block ends, padding and headers with no payload.
    write_blk_bytes(17'd16);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h12, 1'b0, 1'b1);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b0, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);
    send_item(8'h33, 1'b1, 1'b0);
    send_item(8'hCC, 1'b0, 1'b0);
    send_item(8'hDD, 1'b1, 1'b0);
    send_item(8'h9E, 1'b0, 1'b1);
    for (int i = 0; i < 9; i++) send_item(8'(8'h10 + i), 1'b0, 1'b0);

    // The record is mid-way at a full block; seven more bytes of block force an empty middle.
    write_blk_bytes(17'd23);
    send_item(8'h5A, 1'b0, 1'b0);
    rec_left = 4;

    random_items(40, 30);
    run_phase(17'd100, 40, 120);
    run_phase(17'd8, 40, 6);
    run_phase(17'd0, 25, 4);
    run_phase(17'd7, 20, 4);
    run_phase(17'd9, 30, 8);
    run_phase(17'd14, 40, 20);
    steady = 1'b1;
    run_phase(17'd15, 35, 20);
    steady = 1'b0;
    run_phase(17'd131071, 30, 40);
    run_phase(17'd65543, 20, 40);
    run_phase(17'd32768, 40, 40);
    run_phase(17'd3, 20, 5);
    for (int i = 0; i < 3; i++) run_phase(17'($urandom_range(8, 64)), 10, 60);
    run_phase(17'd13, 30, 12);

    wait_drained(20);
    if (sb.errors == 0 && sb.writes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
